[design/ccd_pkg.sv]
`default_nettype none

package ccd_pkg;

  // Field widths of the streams.
  localparam int unsigned IdxW  = 10;
  localparam int unsigned ByteW = 8;
  localparam int unsigned TimeW = 48;
  localparam int unsigned SumW  = 32;
  localparam int unsigned CntW  = 32;

  // The checksum rotates left by RotL, which is a right rotation by RotR.
  localparam int unsigned RotL = 5;
  localparam int unsigned RotR = SumW - RotL;

  localparam int unsigned TableDepthDef = 1024;

  // Stream word widths, padded to whole bytes.
  localparam int unsigned InDataW  = 72;
  localparam int unsigned OutDataW = 192;

  // Result buffer depth and pointer width.
  localparam int unsigned OutDepth = 3;
  localparam int unsigned OutPtrW  = 2;

  // One chunk table entry.
  typedef struct packed {
    logic [TimeW-1:0] change_ms;
    logic [TimeW-1:0] scan_ms;
    logic [CntW-1:0]  scans;
    logic             scanned;
    logic             zero;
    logic [SumW-1:0]  sum;
  } entry_t;

  // A finished chunk on its way to the table update.
  typedef struct packed {
    logic [IdxW-1:0]  idx;
    logic [SumW-1:0]  sum;
    logic             zero;
    logic [TimeW-1:0] now;
  } job_t;

  // Result word; the last member sits in the lowest bits.
  typedef struct packed {
    logic [CntW-1:0]  total_changes;
    logic [CntW-1:0]  total_scans;
    logic [TimeW-1:0] change_time;
    logic [CntW-1:0]  scans_of_chunk;
    logic             first_scan;
    logic             chunk_changed;
    logic             chunk_all_zero;
    logic [SumW-1:0]  chunk_checksum;
    logic [IdxW-1:0]  result_chunk;
  } result_t;

  // Status of the table update stage toward the input handshake.
  typedef struct packed {
    logic clearing;
    logic busy;
  } upd_status_t;

  function automatic logic [SumW-1:0] fold(input logic [SumW-1:0] h,
                                           input logic [ByteW-1:0] b);
    logic [SumW-1:0] rot;
    rot  = {h[RotR-1:0], h[SumW-1:RotR]};
    fold = rot ^ {{(SumW-ByteW){1'b0}}, b};
  endfunction

endpackage

`default_nettype wire

[design/chunk_change_detector.sv]
`default_nettype none

// Chunk change detector. Bytes of a memory chunk stream in one per cycle; the word
// marked tlast closes the chunk and carries the chunk index and the current time.
// A rotate-xor checksum and an all-zero flag are compared with the chunk's entry in
// an on-chip table (TABLE_DEPTH entries, one synchronous RAM), the entry is updated,
// and one result word per chunk passes through the update stage register and the result
// buffer to the output stream. A last byte whose index is TABLE_DEPTH or above closes the
// chunk silently. The input takes one word per clock; it is held off by the three-word
// result buffer when it and the table update stage could not take one more result, and
// after reset, while the table is cleared one entry per cycle: tready stays low until
// every entry is cleared.
module chunk_change_detector #(
  parameter int unsigned TABLE_DEPTH = ccd_pkg::TableDepthDef
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // chunk_index[9:0], data_byte[17:10], now_ms[65:18], zero padding above
  input  wire logic [ccd_pkg::InDataW-1:0]      s_axis_tdata_i,
  input  wire logic                             s_axis_tlast_i,
  output logic                                  m_axis_tvalid_o,
  input  wire logic                             m_axis_tready_i,
  // result_chunk[9:0], chunk_checksum[41:10], chunk_all_zero[42],
  // chunk_changed[43], first_scan[44], scans_of_chunk[76:45],
  // change_time[124:77], total_scans[156:125], total_changes[188:157],
  // zero padding above
  output logic [ccd_pkg::OutDataW-1:0]          m_axis_tdata_o
);

  localparam int unsigned ResW = $bits(ccd_pkg::result_t);

  logic                         accept;
  logic                         job_valid;
  ccd_pkg::job_t                job;
  logic                         res_valid;
  ccd_pkg::result_t             res;
  ccd_pkg::upd_status_t         upd_status;
  ccd_pkg::result_t             out_word;
  logic [ccd_pkg::OutPtrW-1:0]  out_count;
  logic [ccd_pkg::OutPtrW:0]    pending;

  // Results already buffered plus the one in the update stage must leave room for one more.
  assign pending = {1'b0, out_count} + {{ccd_pkg::OutPtrW{1'b0}}, upd_status.busy};
  assign s_axis_tready_o = ~upd_status.clearing &&
                           (pending <= (ccd_pkg::OutPtrW + 1)'(ccd_pkg::OutDepth - 1));
  assign accept = s_axis_tvalid_i & s_axis_tready_o;

  ccd_front #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .idx_i       (s_axis_tdata_i[9:0]),
    .byte_i      (s_axis_tdata_i[17:10]),
    .last_i      (s_axis_tlast_i),
    .now_i       (s_axis_tdata_i[65:18]),
    .job_valid_o (job_valid),
    .job_o       (job)
  );

  ccd_update #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_update (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job),
    .res_valid_o (res_valid),
    .res_o       (res),
    .status_o    (upd_status)
  );

  ccd_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .data_o  (out_word),
    .count_o (out_count)
  );

  assign m_axis_tdata_o = {{(ccd_pkg::OutDataW - ResW){1'b0}}, out_word};

endmodule

`default_nettype wire

[design/ccd_table.sv]
`default_nettype none

module ccd_table #(
  parameter int unsigned DEPTH  = ccd_pkg::TableDepthDef,
  parameter int unsigned ADDR_W = 10
) (
  input  wire logic                clk_i,
  input  wire logic                we_i,
  input  wire logic [ADDR_W-1:0]   waddr_i,
  input  wire ccd_pkg::entry_t     wdata_i,
  input  wire logic                re_i,
  input  wire logic [ADDR_W-1:0]   raddr_i,
  output ccd_pkg::entry_t          rdata_o
);

  ccd_pkg::entry_t mem_q [DEPTH];
  ccd_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[design/ccd_front.sv]
`default_nettype none

module ccd_front #(
  parameter int unsigned TABLE_DEPTH = ccd_pkg::TableDepthDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        accept_i,
  input  wire logic [ccd_pkg::IdxW-1:0]    idx_i,
  input  wire logic [ccd_pkg::ByteW-1:0]   byte_i,
  input  wire logic                        last_i,
  input  wire logic [ccd_pkg::TimeW-1:0]   now_i,
  output logic                             job_valid_o,
  output ccd_pkg::job_t                    job_o
);

  logic [ccd_pkg::SumW-1:0] hash_q, hash_d, hash_next;
  logic                     zero_q, zero_d, zero_next;
  logic                     in_range;

  assign hash_next = ccd_pkg::fold(hash_q, byte_i);
  assign zero_next = zero_q & (byte_i == '0);
  assign in_range  = 32'(idx_i) < 32'(TABLE_DEPTH);

  always_comb begin
    hash_d = hash_q;
    zero_d = zero_q;
    if (accept_i) begin
      if (last_i) begin
        hash_d = '0;
        zero_d = 1'b1;
      end else begin
        hash_d = hash_next;
        zero_d = zero_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= '0;
      zero_q <= 1'b1;
    end else begin
      hash_q <= hash_d;
      zero_q <= zero_d;
    end
  end

  // An all-zero chunk reports a checksum of zero.
  assign job_valid_o = accept_i & last_i & in_range;
  assign job_o.idx   = idx_i;
  assign job_o.sum   = zero_next ? '0 : hash_next;
  assign job_o.zero  = zero_next;
  assign job_o.now   = now_i;

endmodule

`default_nettype wire

[design/ccd_update.sv]
`default_nettype none

module ccd_update #(
  parameter int unsigned TABLE_DEPTH = ccd_pkg::TableDepthDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             job_valid_i,
  input  wire ccd_pkg::job_t    job_i,
  output logic                  res_valid_o,
  output ccd_pkg::result_t      res_o,
  output ccd_pkg::upd_status_t  status_o
);

  localparam int unsigned AddrW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [AddrW+ccd_pkg::IdxW-1:0] job_addr_ext;
  logic [AddrW-1:0]               job_addr;

  logic                 s1_valid_q;
  ccd_pkg::job_t        s1_job_q;
  logic [AddrW-1:0]     s1_addr_q;

  logic                 fwd_valid_q;
  logic [AddrW-1:0]     fwd_addr_q;
  ccd_pkg::entry_t      fwd_entry_q;

  logic                 clr_busy_q, clr_busy_d;
  logic [AddrW-1:0]     clr_addr_q, clr_addr_d;

  logic [ccd_pkg::CntW-1:0] scan_total_q, scan_total_d;
  logic [ccd_pkg::CntW-1:0] change_total_q, change_total_d;

  ccd_pkg::entry_t      rd_entry, cur, upd;
  logic                 first, changed;

  logic                 we;
  logic [AddrW-1:0]     waddr;
  ccd_pkg::entry_t      wdata;

  assign job_addr_ext = {{AddrW{1'b0}}, job_i.idx};
  assign job_addr     = job_addr_ext[AddrW-1:0];

  ccd_table #(
    .DEPTH  (TABLE_DEPTH),
    .ADDR_W (AddrW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (job_valid_i),
    .raddr_i (job_addr),
    .rdata_o (rd_entry)
  );

  // The entry written in the previous cycle is not yet visible in the read data.
  assign cur = (fwd_valid_q && (fwd_addr_q == s1_addr_q)) ? fwd_entry_q : rd_entry;

  assign first   = ~cur.scanned;
  assign changed = ~first && ((cur.sum != s1_job_q.sum) || (cur.zero != s1_job_q.zero));

  always_comb begin
    upd.sum       = s1_job_q.sum;
    upd.zero      = s1_job_q.zero;
    upd.scanned   = 1'b1;
    upd.scans     = cur.scans + 1'b1;
    upd.scan_ms   = s1_job_q.now;
    upd.change_ms = changed ? s1_job_q.now : cur.change_ms;
  end

  assign scan_total_d   = s1_valid_q ? scan_total_q + 1'b1 : scan_total_q;
  assign change_total_d = (s1_valid_q && changed) ? change_total_q + 1'b1 : change_total_q;

  // The clearing pass owns the write port until it is done; no word is taken meanwhile.
  assign we    = s1_valid_q | clr_busy_q;
  assign waddr = clr_busy_q ? clr_addr_q : s1_addr_q;
  assign wdata = clr_busy_q ? '0 : upd;

  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_addr_d = clr_addr_q;
    if (clr_busy_q) begin
      if (clr_addr_q == AddrW'(TABLE_DEPTH - 1)) begin
        clr_busy_d = 1'b0;
      end else begin
        clr_addr_d = clr_addr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q     <= 1'b0;
      fwd_valid_q    <= 1'b0;
      clr_busy_q     <= 1'b1;
      clr_addr_q     <= '0;
      scan_total_q   <= '0;
      change_total_q <= '0;
    end else begin
      s1_valid_q     <= job_valid_i;
      fwd_valid_q    <= s1_valid_q;
      clr_busy_q     <= clr_busy_d;
      clr_addr_q     <= clr_addr_d;
      scan_total_q   <= scan_total_d;
      change_total_q <= change_total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_valid_i) begin
      s1_job_q  <= job_i;
      s1_addr_q <= job_addr;
    end
    if (s1_valid_q) begin
      fwd_addr_q  <= s1_addr_q;
      fwd_entry_q <= upd;
    end
  end

  assign res_valid_o          = s1_valid_q;
  assign res_o.result_chunk   = s1_job_q.idx;
  assign res_o.chunk_checksum = s1_job_q.sum;
  assign res_o.chunk_all_zero = s1_job_q.zero;
  assign res_o.chunk_changed  = changed;
  assign res_o.first_scan     = first;
  assign res_o.scans_of_chunk = upd.scans;
  assign res_o.change_time    = upd.change_ms;
  assign res_o.total_scans    = scan_total_d;
  assign res_o.total_changes  = change_total_d;

  assign status_o.clearing = clr_busy_q;
  assign status_o.busy     = s1_valid_q;

endmodule

`default_nettype wire

[design/ccd_out_buf.sv]
`default_nettype none

module ccd_out_buf (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push_i,
  input  wire ccd_pkg::result_t              data_i,
  output logic                               valid_o,
  input  wire logic                          ready_i,
  output ccd_pkg::result_t                   data_o,
  output logic [ccd_pkg::OutPtrW-1:0]        count_o
);

  ccd_pkg::result_t                slot_q [ccd_pkg::OutDepth];
  logic [ccd_pkg::OutPtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [ccd_pkg::OutPtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [ccd_pkg::OutPtrW-1:0]     count_q, count_d;
  logic                            pop;

  assign valid_o = count_q != '0;
  assign pop     = valid_o & ready_i;
  assign data_o  = slot_q[rd_ptr_q];
  assign count_o = count_q;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == ccd_pkg::OutPtrW'(ccd_pkg::OutDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == ccd_pkg::OutPtrW'(ccd_pkg::OutDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

[dv/tb_chunk_change_detector.sv]
`timescale 1ns / 100ps

module tb_chunk_change_detector;

  localparam int unsigned Chunks     = ccd_pkg::TableDepthDef;
  localparam int unsigned PoolSize   = 12;
  localparam int unsigned MaxLen     = 40;
  localparam int unsigned CycleLimit = 200000;

  logic                         clk       = 1'b0;
  logic                         rst_n     = 1'b0;
  logic                         in_valid  = 1'b0;
  logic [ccd_pkg::InDataW-1:0]  in_data   = '0;
  logic                         in_last   = 1'b0;
  logic                         in_ready;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [ccd_pkg::OutDataW-1:0] out_data;

  int tx_idle = 0;
  int rx_idle = 0;
  int n_errors = 0;
  int n_results = 0;
  int n_words = 0;
  int n_changed = 0;
  int n_first = 0;

  // Predicted chunk table and running checksum.
  logic [ccd_pkg::SumW-1:0]  run_sum;
  logic                      run_zero;
  logic [ccd_pkg::SumW-1:0]  tab_sum       [Chunks];
  logic                      tab_zero      [Chunks];
  logic                      tab_seen      [Chunks];
  logic [ccd_pkg::CntW-1:0]  tab_scans     [Chunks];
  logic [ccd_pkg::TimeW-1:0] tab_change_ms [Chunks];
  logic [ccd_pkg::CntW-1:0]  pred_scans;
  logic [ccd_pkg::CntW-1:0]  change_count;
  ccd_pkg::result_t          expected_results[$];

  // Contents of the chunk about to be sent, and remembered contents per pool slot.
  logic [ccd_pkg::ByteW-1:0] chunk_buf [MaxLen];
  int                        chunk_len;
  logic [ccd_pkg::IdxW-1:0]  pool_idx   [PoolSize];
  logic [ccd_pkg::ByteW-1:0] pool_bytes [PoolSize][MaxLen];
  int                        pool_len   [PoolSize];

  chunk_change_detector u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (in_ready),
    .s_axis_tdata_i  (in_data),
    .s_axis_tlast_i  (in_last),
    .m_axis_tvalid_o (out_valid),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (out_data)
  );

  initial forever #2 clk = ~clk;

  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("timeout after %0d cycles", CycleLimit);
    $display("tb_chunk_change_detector: done, errors");
    $finish;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_idle);
  end

  function automatic void clear_table_model();
    run_sum      = '0;
    run_zero     = 1'b1;
    pred_scans   = '0;
    change_count = '0;
    for (int i = 0; i < Chunks; i++) begin
      tab_sum[i]       = '0;
      tab_zero[i]      = 1'b0;
      tab_seen[i]      = 1'b0;
      tab_scans[i]     = '0;
      tab_change_ms[i] = '0;
    end
  endfunction

  // Folds one accepted word into the running checksum and, on an in-range last
  // byte, updates the table and queues the result the block should produce.
  function automatic void scan_word(input logic [ccd_pkg::IdxW-1:0] idx,
                                    input logic [ccd_pkg::ByteW-1:0] b,
                                    input logic last,
                                    input logic [ccd_pkg::TimeW-1:0] now);
    ccd_pkg::result_t         r;
    logic [ccd_pkg::SumW-1:0] sum;
    logic                     zero;
    run_sum = {run_sum[ccd_pkg::SumW-ccd_pkg::RotL-1:0],
               run_sum[ccd_pkg::SumW-1:ccd_pkg::SumW-ccd_pkg::RotL]} ^ ccd_pkg::SumW'(b);
    if (b != '0) run_zero = 1'b0;
    if (!last) return;
    sum      = run_zero ? '0 : run_sum;
    zero     = run_zero;
    run_sum  = '0;
    run_zero = 1'b1;
    if (int'(idx) >= Chunks) return;
    r.first_scan    = !tab_seen[idx];
    r.chunk_changed = tab_seen[idx] && (tab_sum[idx] != sum || tab_zero[idx] != zero);
    tab_sum[idx]   = sum;
    tab_zero[idx]  = zero;
    tab_seen[idx]  = 1'b1;
    tab_scans[idx] = tab_scans[idx] + 1'b1;
    if (r.chunk_changed) begin
      tab_change_ms[idx] = now;
      change_count       = change_count + 1'b1;
      n_changed++;
    end
    if (r.first_scan) n_first++;
    pred_scans = pred_scans + 1'b1;
    r.result_chunk   = idx;
    r.chunk_checksum = sum;
    r.chunk_all_zero = zero;
    r.scans_of_chunk = tab_scans[idx];
    r.change_time    = tab_change_ms[idx];
    r.total_scans    = pred_scans;
    r.total_changes  = change_count;
    expected_results.push_back(r);
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    n_errors++;
    $display("[%0t] mismatch in %s: got %0h, want %0h", $time, what, got, want);
  endtask

  always @(posedge clk) begin : check_results
    ccd_pkg::result_t got;
    ccd_pkg::result_t want;
    if (out_valid && out_ready) begin
      got = ccd_pkg::result_t'(out_data[$bits(ccd_pkg::result_t)-1:0]);
      n_results++;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, chunk", 64'(got.result_chunk), 64'd0);
      end else begin
        want = expected_results.pop_front();
        if (got.result_chunk !== want.result_chunk)
          report_mismatch("result_chunk", 64'(got.result_chunk), 64'(want.result_chunk));
        if (got.chunk_checksum !== want.chunk_checksum)
          report_mismatch("chunk_checksum", 64'(got.chunk_checksum),
                          64'(want.chunk_checksum));
        if (got.chunk_all_zero !== want.chunk_all_zero)
          report_mismatch("chunk_all_zero", 64'(got.chunk_all_zero),
                          64'(want.chunk_all_zero));
        if (got.chunk_changed !== want.chunk_changed)
          report_mismatch("chunk_changed", 64'(got.chunk_changed), 64'(want.chunk_changed));
        if (got.first_scan !== want.first_scan)
          report_mismatch("first_scan", 64'(got.first_scan), 64'(want.first_scan));
        if (got.scans_of_chunk !== want.scans_of_chunk)
          report_mismatch("scans_of_chunk", 64'(got.scans_of_chunk),
                          64'(want.scans_of_chunk));
        if (got.change_time !== want.change_time)
          report_mismatch("change_time", 64'(got.change_time), 64'(want.change_time));
        if (got.total_scans !== want.total_scans)
          report_mismatch("total_scans", 64'(got.total_scans), 64'(want.total_scans));
        if (got.total_changes !== want.total_changes)
          report_mismatch("total_changes", 64'(got.total_changes),
                          64'(want.total_changes));
      end
    end
  end

  function automatic logic [ccd_pkg::TimeW-1:0] rand_ms();
    logic [15:0] hi;
    case ($urandom_range(9))
      0: rand_ms = '0;
      1: rand_ms = '1;
      default: begin
        hi      = 16'($urandom);
        rand_ms = {hi, 32'($urandom)};
      end
    endcase
  endfunction

  // Sends one word; valid stays high after acceptance so back-to-back words
  // need no extra assignment in the same step.
  task automatic send_word(input logic [ccd_pkg::IdxW-1:0] idx,
                           input logic [ccd_pkg::ByteW-1:0] b,
                           input logic last,
                           input logic [ccd_pkg::TimeW-1:0] now);
    while ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= ccd_pkg::InDataW'({now, b, idx});
    in_last  <= last;
    do @(posedge clk); while (!in_ready);
    n_words++;
    scan_word(idx, b, last, now);
  endtask

  // The index and time on bytes before the last are ignored, so they get noise.
  task automatic send_chunk(input logic [ccd_pkg::IdxW-1:0] idx,
                            input logic [ccd_pkg::TimeW-1:0] now);
    for (int i = 0; i < chunk_len - 1; i++) begin
      send_word(ccd_pkg::IdxW'($urandom), chunk_buf[i], 1'b0, rand_ms());
    end
    send_word(idx, chunk_buf[chunk_len-1], 1'b1, now);
  endtask

  task automatic wait_for_results(input int tail);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic run_reset();
    clear_table_model();
    rst_n <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  endtask

  task automatic check_single_byte_chunks();
    chunk_len    = 1;
    chunk_buf[0] = 8'h00;
    send_chunk('0, '0);
    chunk_buf[0] = 8'hFF;
    send_chunk('0, '1);
    send_chunk('0, ccd_pkg::TimeW'(1));
  endtask

  task automatic check_extreme_indexes();
    chunk_len    = 2;
    chunk_buf[0] = 8'hFF;
    chunk_buf[1] = 8'h80;
    send_chunk('1, '1);
    send_chunk('1, ccd_pkg::TimeW'(2));
  endtask

  // Bytes 01 then 20 fold to a zero checksum, so only the zero flag differs
  // from a stored all-zero chunk.
  task automatic check_zero_flag_without_sum_change();
    chunk_len    = 2;
    chunk_buf[0] = 8'h00;
    chunk_buf[1] = 8'h00;
    send_chunk(ccd_pkg::IdxW'(5), ccd_pkg::TimeW'(10));
    chunk_buf[0] = 8'h01;
    chunk_buf[1] = 8'h20;
    send_chunk(ccd_pkg::IdxW'(5), ccd_pkg::TimeW'(20));
    chunk_len    = 3;
    chunk_buf[0] = 8'h00;
    chunk_buf[1] = 8'h00;
    chunk_buf[2] = 8'h00;
    send_chunk(ccd_pkg::IdxW'(5), ccd_pkg::TimeW'(30));
  endtask

  task automatic check_long_chunk();
    chunk_len = 8;
    for (int i = 0; i < chunk_len; i++) chunk_buf[i] = 8'($urandom);
    send_chunk(ccd_pkg::IdxW'(512), rand_ms());
  endtask

  task automatic fill_random_bytes(input int len, input bit all_zero);
    chunk_len = len;
    for (int i = 0; i < len; i++) begin
      chunk_buf[i] = (all_zero || $urandom_range(3) == 0) ? 8'h00 : 8'($urandom);
    end
  endtask

  // Mostly rescans of a small pool of chunks, so that unchanged and changed
  // scans both occur often; the rest go to random indexes.
  task automatic check_random_scans(input int tx_pct, input int rx_pct, input int words);
    int start;
    int slot;
    int len;
    logic [ccd_pkg::IdxW-1:0] idx;
    tx_idle = tx_pct;
    rx_idle = rx_pct;
    start   = n_words;
    while (n_words - start < words) begin
      len  = ($urandom_range(9) == 0) ? $urandom_range(MaxLen, 7) : $urandom_range(6, 1);
      slot = $urandom_range(PoolSize - 1);
      if ($urandom_range(4) == 0) begin
        fill_random_bytes(len, $urandom_range(7) == 0);
        idx = ccd_pkg::IdxW'($urandom);
      end else begin
        idx = pool_idx[slot];
        case ($urandom_range(9)) inside
          [0:3]: begin
            chunk_len = pool_len[slot];
            for (int i = 0; i < chunk_len; i++) chunk_buf[i] = pool_bytes[slot][i];
          end
          4: fill_random_bytes(len, 1'b1);
          5: begin
            chunk_len = pool_len[slot];
            for (int i = 0; i < chunk_len; i++) chunk_buf[i] = pool_bytes[slot][i];
            chunk_buf[$urandom_range(chunk_len - 1)] ^= 8'(1 << $urandom_range(7));
          end
          default: fill_random_bytes(len, 1'b0);
        endcase
        pool_len[slot] = chunk_len;
        for (int i = 0; i < chunk_len; i++) pool_bytes[slot][i] = chunk_buf[i];
      end
      send_chunk(idx, rand_ms());
    end
  endtask

  initial begin
    for (int s = 0; s < PoolSize; s++) begin
      pool_idx[s] = (s == 0) ? '0 : (s == 1) ? '1 : ccd_pkg::IdxW'($urandom);
      pool_len[s] = 1;
      pool_bytes[s][0] = 8'h00;
    end
    tx_idle = 34;
    rx_idle = 71;
    run_reset();
    check_single_byte_chunks();
    check_extreme_indexes();
    check_zero_flag_without_sum_change();
    check_long_chunk();
    check_random_scans(34, 71, 560);
    wait_for_results(4);
    check_random_scans(71, 34, 560);
    wait_for_results(4);
    check_random_scans(0, 0, 560);
    wait_for_results(20);
    if (expected_results.size() != 0) begin
      report_mismatch("results never delivered", 64'(expected_results.size()), 64'd0);
    end
    $display("sent %0d words forming %0d checked chunk results", n_words, n_results);
    $display("covered %0d first scans and %0d detected changes", n_first, n_changed);
    if (n_errors == 0) begin
      $display("tb_chunk_change_detector: done, clean");
    end else begin
      $display("tb_chunk_change_detector: done, errors");
    end
    $finish;
  end

endmodule

[sim.f]
design/ccd_pkg.sv
design/ccd_table.sv
design/ccd_front.sv
design/ccd_update.sv
design/ccd_out_buf.sv
design/chunk_change_detector.sv
dv/tb_chunk_change_detector.sv
